// ----- hw/rtl/pgpe_pkg.sv -----
`timescale 1ns / 1ps
package pgpe_pkg;

  // widest grid address over the whole parameter range (4096 rows by 65536 sites)
  localparam int ADDR_MAX_W = 28;

  // result status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_CONFLICT = 2'd1;
  localparam logic [1:0] ST_SKIP     = 2'd2;
  localparam logic [1:0] ST_OOG      = 2'd3;

  // orientation codes
  localparam logic [2:0] ORIENT_N  = 3'd0;
  localparam logic [2:0] ORIENT_FS = 3'd1;

  // configuration register indexes
  localparam logic [1:0] CFG_SITE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_ROW_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_MULTI_HEIGHT = 2'd2;

  // operation codes
  localparam logic OP_PAINT = 1'b0;
  localparam logic OP_ERASE = 1'b1;

  typedef enum logic [1:0] {
    K_PAINT,
    K_ERASE,
    K_SKIP,
    K_OOG
  } kind_t;

  // classified item handed from front to back
  typedef struct packed {
    kind_t                 kind;
    logic [19:0]           owner;
    logic [ADDR_MAX_W-1:0] base;
    logic [15:0]           xstep;
    logic [15:0]           ystep;
    logic [25:0]           x_coord;
    logic [23:0]           y_coord;
    logic                  orient_set;
    logic [2:0]            orient;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] conflict_owner;
    logic [25:0] x_coord;
    logic [23:0] y_coord;
    logic        orient_set;
    logic [2:0]  orient;
  } res_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_DIVX,
    F_WX,
    F_DIVY,
    F_WY,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_CHK_RD,
    B_CHK_EV,
    B_WR
  } back_state_t;

endpackage

// ----- hw/rtl/pgpe_div.sv -----
`timescale 1ns / 1ps
module pgpe_div
  import pgpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quotient_ceil
);

  logic        run;
  logic [3:0]  count;
  logic [15:0] rem;
  logic [15:0] quo;
  logic [15:0] dvs;
  logic [16:0] shifted;
  logic [16:0] diff;
  logic [16:0] q_up;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign shifted = {rem, quo[15]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run   <= 1'b1;
        count <= 4'd15;
        rem   <= '0;
        quo   <= dividend;
        dvs   <= divisor;
      end else if (run) begin
        if (!diff[16]) begin
          rem <= diff[15:0];
          quo <= {quo[14:0], 1'b1};
        end else begin
          rem <= shifted[15:0];
          quo <= {quo[14:0], 1'b0};
        end
        count <= count - 4'd1;
        if (count == 4'd0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // round up when a remainder is left
  assign q_up          = {1'b0, quo} + {16'd0, (rem != 16'd0)};
  assign quotient_ceil = q_up[15:0];

endmodule

// ----- hw/rtl/pgpe_front.sv -----
`timescale 1ns / 1ps
module pgpe_front
  import pgpe_pkg::*;
#(
  parameter int GRID_ROWS  = 256,
  parameter int GRID_SITES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        front_busy,
  input  logic        op,
  input  logic [19:0] cell_id,
  input  logic [9:0]  x_site,
  input  logic [7:0]  y_row,
  input  logic [15:0] cell_width,
  input  logic [15:0] cell_height,
  input  logic        cell_fixed,
  input  logic        cell_placed,
  input  logic        cell_top_power,
  input  logic        row_top_power,
  input  logic [2:0]  row_orient,
  input  logic [15:0] site_width,
  input  logic [15:0] row_height,
  input  logic        multi_height_mode,
  input  logic        q_full,
  output logic        q_push,
  output item_t       q_item
);

  front_state_t state, state_next;

  logic        op_r;
  logic [19:0] id_r;
  logic [9:0]  xs_r;
  logic [7:0]  yr_r;
  logic [15:0] cw_r;
  logic [15:0] ch_r;
  logic        fixed_r;
  logic        placed_r;
  logic        ctp_r;
  logic        rtp_r;
  logic [2:0]  rori_r;
  logic [15:0] xstep;
  logic [15:0] ystep;

  logic        div_go;
  logic        div_done;
  logic [15:0] div_a;
  logic [15:0] div_b;
  logic [15:0] div_q;
  logic [15:0] sw1;
  logic [15:0] rh1;
  logic        accept;
  logic        skip;
  logic        oog;
  logic [31:0] base_full;

  // zero size registers act as one
  assign sw1    = (site_width == 16'd0) ? 16'd1 : site_width;
  assign rh1    = (row_height == 16'd0) ? 16'd1 : row_height;
  assign accept = start && (state == F_IDLE);
  assign front_busy = (state != F_IDLE);

  pgpe_div u_div (
    .clk           (clk),
    .rst           (rst),
    .go            (div_go),
    .dividend      (div_a),
    .divisor       (div_b),
    .done          (div_done),
    .quotient_ceil (div_q)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // item capture and step counts
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= op;
      id_r     <= cell_id;
      xs_r     <= x_site;
      yr_r     <= y_row;
      cw_r     <= cell_width;
      ch_r     <= cell_height;
      fixed_r  <= cell_fixed;
      placed_r <= cell_placed;
      ctp_r    <= cell_top_power;
      rtp_r    <= row_top_power;
      rori_r   <= row_orient;
    end
    if (state == F_WX && div_done) begin
      xstep <= div_q;
    end
    if (state == F_WY && div_done) begin
      ystep <= div_q;
    end
  end

  // classification
  assign skip = (op_r == OP_ERASE) && (fixed_r || !placed_r);
  assign oog  = (32'(xs_r) >= GRID_SITES) || (32'(yr_r) >= GRID_ROWS) ||
                (32'(xs_r) + 32'(xstep) > GRID_SITES) ||
                (32'(yr_r) + 32'(ystep) > GRID_ROWS);
  assign base_full = 32'(yr_r) * GRID_SITES + 32'(xs_r);

  always_comb begin
    if (skip) begin
      q_item.kind = K_SKIP;
    end else if (oog) begin
      q_item.kind = K_OOG;
    end else if (op_r == OP_ERASE) begin
      q_item.kind = K_ERASE;
    end else begin
      q_item.kind = K_PAINT;
    end
    q_item.owner   = id_r;
    q_item.base    = base_full[ADDR_MAX_W-1:0];
    q_item.xstep   = xstep;
    q_item.ystep   = ystep;
    q_item.x_coord = 26'(xs_r) * 26'(sw1);
    q_item.y_coord = 24'(yr_r) * 24'(rh1);
    if (multi_height_mode) begin
      q_item.orient_set = ystep[0];
      if (!ystep[0]) begin
        q_item.orient = ORIENT_N;
      end else if (rtp_r != ctp_r) begin
        q_item.orient = ORIENT_FS;
      end else begin
        q_item.orient = ORIENT_N;
      end
    end else begin
      q_item.orient_set = 1'b1;
      q_item.orient     = rori_r;
    end
  end

  // sequencer: two divisions, then hand over
  always_comb begin
    state_next = state;
    div_go     = 1'b0;
    div_a      = cw_r;
    div_b      = sw1;
    q_push     = 1'b0;
    case (state)
      F_IDLE: begin
        if (accept) state_next = F_DIVX;
      end
      F_DIVX: begin
        div_go     = 1'b1;
        state_next = F_WX;
      end
      F_WX: begin
        if (div_done) state_next = F_DIVY;
      end
      F_DIVY: begin
        div_go     = 1'b1;
        div_a      = ch_r;
        div_b      = rh1;
        state_next = F_WY;
      end
      F_WY: begin
        if (div_done) state_next = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push     = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/pgpe_fifo.sv -----
`timescale 1ns / 1ps
module pgpe_fifo
  import pgpe_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t din,
  input  logic  pop,
  output item_t dout,
  output logic  full,
  output logic  empty
);

  item_t      slot [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign dout  = slot[rp];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wp] <= din;
  end

endmodule

// ----- hw/rtl/pgpe_back.sv -----
`timescale 1ns / 1ps
module pgpe_back
  import pgpe_pkg::*;
#(
  parameter int GRID_ROWS    = 256,
  parameter int GRID_SITES   = 1024,
  parameter int CELL_ID_BITS = 20
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  q_empty,
  input  item_t q_item,
  output logic  q_pop,
  output logic  clearing,
  output logic  strobe,
  output res_t  res
);

  localparam int DEPTH = GRID_ROWS * GRID_SITES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  back_state_t state, state_next;

  logic [CELL_ID_BITS:0] mem [DEPTH];
  logic [CELL_ID_BITS:0] rd_data;
  logic [CELL_ID_BITS:0] wdata;
  logic [AW-1:0]         waddr;
  logic                  we;

  item_t         cur, cur_next;
  logic [AW-1:0] addr, addr_next;
  logic [AW-1:0] row_addr, row_addr_next;
  logic [AW-1:0] clr_cnt, clr_cnt_next;
  logic [15:0]   col, col_next;
  logic [15:0]   row, row_next;
  logic          res_fire;
  res_t          res_val;
  logic          last_col;
  logic          last_site;
  logic [31:0]   owner_wide;
  logic [31:0]   hit_wide;

  assign clearing  = (state == B_CLEAR);
  assign last_col  = (col == cur.xstep - 16'd1);
  assign last_site = last_col && (row == cur.ystep - 16'd1);
  assign owner_wide = 32'(cur.owner);
  assign hit_wide   = 32'(rd_data[CELL_ID_BITS-1:0]);

  // occupancy memory
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_data <= mem[addr];
  end

  // state, walk position and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_CLEAR;
      clr_cnt <= '0;
      strobe  <= 1'b0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
      strobe  <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    addr     <= addr_next;
    row_addr <= row_addr_next;
    col      <= col_next;
    row      <= row_next;
    if (res_fire) res <= res_val;
  end

  always_comb begin
    state_next    = state;
    cur_next      = cur;
    addr_next     = addr;
    row_addr_next = row_addr;
    col_next      = col;
    row_next      = row;
    clr_cnt_next  = clr_cnt;
    q_pop         = 1'b0;
    we            = 1'b0;
    waddr         = addr;
    wdata         = '0;
    res_fire      = 1'b0;
    res_val       = '0;
    case (state)
      // sweep every entry to empty after reset
      B_CLEAR: begin
        we           = 1'b1;
        waddr        = clr_cnt;
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == AW'(DEPTH - 1)) state_next = B_IDLE;
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop         = 1'b1;
          cur_next      = q_item;
          addr_next     = q_item.base[AW-1:0];
          row_addr_next = q_item.base[AW-1:0];
          col_next      = '0;
          row_next      = '0;
          case (q_item.kind)
            K_SKIP: begin
              res_fire       = 1'b1;
              res_val.status = ST_SKIP;
            end
            K_OOG: begin
              res_fire       = 1'b1;
              res_val.status = ST_OOG;
            end
            K_ERASE: begin
              if (q_item.xstep == 16'd0 || q_item.ystep == 16'd0) begin
                res_fire       = 1'b1;
                res_val.status = ST_DONE;
              end else begin
                state_next = B_WR;
              end
            end
            default: begin
              if (q_item.xstep == 16'd0 || q_item.ystep == 16'd0) begin
                // empty rectangle paints trivially
                res_fire           = 1'b1;
                res_val.status     = ST_DONE;
                res_val.x_coord    = q_item.x_coord;
                res_val.y_coord    = q_item.y_coord;
                res_val.orient_set = q_item.orient_set;
                res_val.orient     = q_item.orient;
              end else begin
                state_next = B_CHK_RD;
              end
            end
          endcase
        end
      end
      // read issued from addr this cycle
      B_CHK_RD: begin
        state_next = B_CHK_EV;
      end
      B_CHK_EV: begin
        if (rd_data[CELL_ID_BITS]) begin
          res_fire               = 1'b1;
          res_val.status         = ST_CONFLICT;
          res_val.conflict_owner = hit_wide[19:0];
          state_next             = B_IDLE;
        end else if (last_site) begin
          // whole rectangle free: rewind for the write pass
          addr_next     = cur.base[AW-1:0];
          row_addr_next = cur.base[AW-1:0];
          col_next      = '0;
          row_next      = '0;
          state_next    = B_WR;
        end else begin
          if (last_col) begin
            col_next      = '0;
            row_next      = row + 16'd1;
            row_addr_next = row_addr + AW'(GRID_SITES);
            addr_next     = row_addr + AW'(GRID_SITES);
          end else begin
            col_next  = col + 16'd1;
            addr_next = addr + 1'b1;
          end
          state_next = B_CHK_RD;
        end
      end
      B_WR: begin
        we = 1'b1;
        if (cur.kind == K_PAINT) begin
          wdata = {1'b1, owner_wide[CELL_ID_BITS-1:0]};
        end
        if (last_site) begin
          res_fire       = 1'b1;
          res_val.status = ST_DONE;
          if (cur.kind == K_PAINT) begin
            res_val.x_coord    = cur.x_coord;
            res_val.y_coord    = cur.y_coord;
            res_val.orient_set = cur.orient_set;
            res_val.orient     = cur.orient;
          end
          state_next = B_IDLE;
        end else if (last_col) begin
          col_next      = '0;
          row_next      = row + 16'd1;
          row_addr_next = row_addr + AW'(GRID_SITES);
          addr_next     = row_addr + AW'(GRID_SITES);
        end else begin
          col_next  = col + 16'd1;
          addr_next = addr + 1'b1;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/placement_grid_paint_erase.sv -----
`timescale 1ns / 1ps
// Site occupancy grid with paint and erase of cell rectangles.
// Items: raise start with the item fields; the item transfers on a rising edge
// with start high and busy low. Each item gives exactly one result, shown for
// one cycle with strobe high; the receiver cannot stall, so results are never
// held back by the output side.
// Configuration: cfg_valid/cfg_ready (ready always high) with cfg_index and
// cfg_data; index 0 site_width, 1 row_height, 2 multi_height_mode. Write only
// while idle.
// Flow: after a transfer the front stays busy through two 16-step ceiling
// divisions and its sequencing states, so it takes no new item until it has
// handed the last one on; it hands each item to a two-entry queue and waits
// there while the queue is full. The back walks the grid memory one site at
// a time: a paint reads and checks every covered site, then writes each one;
// an erase only writes each site. The front takes the next item while the
// back is still walking.
// Reset: rst clears control state and starts a clearing pass that empties all
// GRID_ROWS*GRID_SITES entries, one per cycle (262144 entries at the default
// size); busy stays high until it ends.
module placement_grid_paint_erase
  import pgpe_pkg::*;
#(
  parameter int GRID_ROWS    = 256,
  parameter int GRID_SITES   = 1024,
  parameter int CELL_ID_BITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [19:0] cell_id,
  input  logic [9:0]  x_site,
  input  logic [7:0]  y_row,
  input  logic [15:0] cell_width,
  input  logic [15:0] cell_height,
  input  logic        cell_fixed,
  input  logic        cell_placed,
  input  logic        cell_top_power,
  input  logic        row_top_power,
  input  logic [2:0]  row_orient,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        strobe,
  output logic [1:0]  status,
  output logic [19:0] conflict_owner,
  output logic [25:0] x_coord,
  output logic [23:0] y_coord,
  output logic        orient_set,
  output logic [2:0]  orient
);

  logic [15:0] site_width;
  logic [15:0] row_height;
  logic        multi_height_mode;
  logic        front_busy;
  logic        clearing;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;
  item_t       q_in;
  item_t       q_out;
  res_t        res;

  assign cfg_ready = 1'b1;
  assign busy      = front_busy || clearing;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      site_width        <= 16'd200;
      row_height        <= 16'd2000;
      multi_height_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SITE_WIDTH:   site_width        <= cfg_data;
        CFG_ROW_HEIGHT:   row_height        <= cfg_data;
        CFG_MULTI_HEIGHT: multi_height_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pgpe_front #(
    .GRID_ROWS  (GRID_ROWS),
    .GRID_SITES (GRID_SITES)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .start             (start && !clearing),
    .front_busy        (front_busy),
    .op                (op),
    .cell_id           (cell_id),
    .x_site            (x_site),
    .y_row             (y_row),
    .cell_width        (cell_width),
    .cell_height       (cell_height),
    .cell_fixed        (cell_fixed),
    .cell_placed       (cell_placed),
    .cell_top_power    (cell_top_power),
    .row_top_power     (row_top_power),
    .row_orient        (row_orient),
    .site_width        (site_width),
    .row_height        (row_height),
    .multi_height_mode (multi_height_mode),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_item            (q_in)
  );

  pgpe_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .pop   (q_pop),
    .dout  (q_out),
    .full  (q_full),
    .empty (q_empty)
  );

  pgpe_back #(
    .GRID_ROWS    (GRID_ROWS),
    .GRID_SITES   (GRID_SITES),
    .CELL_ID_BITS (CELL_ID_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_item   (q_out),
    .q_pop    (q_pop),
    .clearing (clearing),
    .strobe   (strobe),
    .res      (res)
  );

  assign status         = res.status;
  assign conflict_owner = res.conflict_owner;
  assign x_coord        = res.x_coord;
  assign y_coord        = res.y_coord;
  assign orient_set     = res.orient_set;
  assign orient         = res.orient;

  // no result while the grid is still being cleared
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !strobe) else $error("result during clearing pass");

  // a transferred item keeps the front busy in the next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy low after item transfer");

  // only a done result carries coordinates
  a_coords_only_done: assert property (@(posedge clk) disable iff (rst)
    (strobe && status != ST_DONE) |-> (x_coord == 26'd0 && y_coord == 24'd0 &&
    orient_set == 1'b0)) else $error("coordinates on a non-done result");

  // the queue is never pushed when full or popped when empty
  a_queue_sane: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full) && !(q_pop && q_empty)) else $error("queue misuse");

endmodule
